// ===== rtl/ict_pkg.sv =====
// shared types, codes and defaults for the input change tracker
package ict_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned IdW  = 5;
  localparam int unsigned ValW = 8;

  localparam int unsigned NumKeysDef     = 16;
  localparam int unsigned NumEncodersDef = 8;
  localparam int unsigned NumButtonsDef  = 32;
  localparam int unsigned NumPotsDef     = 8;

  // item opcodes
  localparam logic [OpW-1:0] OP_KEY = 3'd0;
  localparam logic [OpW-1:0] OP_ENC = 3'd1;
  localparam logic [OpW-1:0] OP_BTN = 3'd2;
  localparam logic [OpW-1:0] OP_POT = 3'd3;
  localparam logic [OpW-1:0] OP_POP = 3'd4;

  // reported change kinds
  localparam logic [OpW-1:0] KIND_NONE = 3'd0;
  localparam logic [OpW-1:0] KIND_KEY  = 3'd1;
  localparam logic [OpW-1:0] KIND_ENC  = 3'd2;
  localparam logic [OpW-1:0] KIND_BTN  = 3'd3;
  localparam logic [OpW-1:0] KIND_POT  = 3'd4;

  // encoder accumulator limits
  localparam logic signed [ValW-1:0] SatMax = 8'sd127;
  localparam logic signed [ValW-1:0] SatMin = -8'sd127;

  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic [IdW-1:0]         source_id;
    logic                   is_pressed;
    logic signed [ValW-1:0] step_delta;
    logic [ValW-1:0]        level;
  } item_t;

  typedef struct packed {
    logic [OpW-1:0]         change_kind;
    logic [IdW-1:0]         change_index;
    logic                   change_pressed;
    logic signed [ValW-1:0] change_delta;
    logic [ValW-1:0]        change_level;
    logic                   pending;
  } result_t;

endpackage

// ===== rtl/ict_if.sv =====
// valid/ready channel interfaces for items and results
interface ict_in_if;
  logic                            valid;
  logic                            ready;
  logic [ict_pkg::OpW-1:0]         opcode;
  logic [ict_pkg::IdW-1:0]         source_id;
  logic                            is_pressed;
  logic signed [ict_pkg::ValW-1:0] step_delta;
  logic [ict_pkg::ValW-1:0]        level;

  modport source (output valid, opcode, source_id, is_pressed, step_delta, level,
                  input ready);
  modport sink (input valid, opcode, source_id, is_pressed, step_delta, level,
                output ready);
endinterface

interface ict_out_if;
  logic                            valid;
  logic                            ready;
  logic [ict_pkg::OpW-1:0]         change_kind;
  logic [ict_pkg::IdW-1:0]         change_index;
  logic                            change_pressed;
  logic signed [ict_pkg::ValW-1:0] change_delta;
  logic [ict_pkg::ValW-1:0]        change_level;
  logic                            pending;

  modport source (output valid, change_kind, change_index, change_pressed, change_delta,
                  change_level, pending, input ready);
  modport sink (input valid, change_kind, change_index, change_pressed, change_delta,
                change_level, pending, output ready);
endinterface

// ===== rtl/ict_in_stage.sv =====
// input register stage: holds one accepted item until the result register has room
module ict_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  ict_in_if.sink          in_i,
  input  logic            room_i,
  output logic            fire_o,
  output ict_pkg::item_t  item_o
);

  logic           valid_q, valid_d;
  ict_pkg::item_t item_q;
  logic           accept;

  assign fire_o    = valid_q & room_i;
  assign in_i.ready = ~valid_q | room_i;
  assign accept    = in_i.valid & in_i.ready;
  assign item_o    = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode     <= in_i.opcode;
      item_q.source_id  <= in_i.source_id;
      item_q.is_pressed <= in_i.is_pressed;
      item_q.step_delta <= in_i.step_delta;
      item_q.level      <= in_i.level;
    end
  end

endmodule

// ===== rtl/ict_core.sv =====
// tracker state, update logic and fixed-priority pop selection
module ict_core #(
  parameter int unsigned NUM_KEYS     = ict_pkg::NumKeysDef,
  parameter int unsigned NUM_ENCODERS = ict_pkg::NumEncodersDef,
  parameter int unsigned NUM_BUTTONS  = ict_pkg::NumButtonsDef,
  parameter int unsigned NUM_POTS     = ict_pkg::NumPotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ict_pkg::item_t   item_i,
  output ict_pkg::result_t result_o
);

  localparam int unsigned VW = ict_pkg::ValW;
  localparam int unsigned IW = ict_pkg::IdW;

  logic [NUM_KEYS-1:0]     key_state_q, key_state_d, key_marks_q, key_marks_d;
  logic [NUM_BUTTONS-1:0]  btn_state_q, btn_state_d, btn_marks_q, btn_marks_d;
  logic [NUM_ENCODERS-1:0] enc_marks_q, enc_marks_d;
  logic [NUM_POTS-1:0]     pot_marks_q, pot_marks_d;
  logic signed [VW-1:0]    enc_sum_q [NUM_ENCODERS];
  logic signed [VW-1:0]    enc_sum_d [NUM_ENCODERS];
  logic [VW-1:0]           pot_level_q [NUM_POTS];
  logic [VW-1:0]           pot_level_d [NUM_POTS];

  // one-hot decode of the update id, all zero when out of range
  logic [NUM_KEYS-1:0]     key_hit, key_pick;
  logic [NUM_BUTTONS-1:0]  btn_hit, btn_pick;
  logic [NUM_ENCODERS-1:0] enc_hit, enc_pick, enc_sel;
  logic [NUM_POTS-1:0]     pot_hit, pot_pick, pot_sel;
  logic [IW-1:0]           key_idx, btn_idx, enc_idx, pot_idx;

  logic                 is_pop, take_key, take_enc, take_btn, take_pot;
  logic                 key_was, btn_was;
  logic signed [VW-1:0] enc_rd, enc_new;
  logic signed [VW:0]   enc_acc;
  logic [VW-1:0]        pot_rd;

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) key_hit[i] = (item_i.source_id == IW'(i));
    for (int i = 0; i < NUM_BUTTONS; i++) btn_hit[i] = (item_i.source_id == IW'(i));
    for (int i = 0; i < NUM_ENCODERS; i++) enc_hit[i] = (item_i.source_id == IW'(i));
    for (int i = 0; i < NUM_POTS; i++) pot_hit[i] = (item_i.source_id == IW'(i));
  end

  // lowest dirty entry of each group, scanning down so the lowest wins
  always_comb begin
    key_pick = '0;
    key_idx  = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (key_marks_q[i]) begin
        key_pick    = '0;
        key_pick[i] = 1'b1;
        key_idx     = IW'(i);
      end
    end
    btn_pick = '0;
    btn_idx  = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (btn_marks_q[i]) begin
        btn_pick    = '0;
        btn_pick[i] = 1'b1;
        btn_idx     = IW'(i);
      end
    end
    enc_pick = '0;
    enc_idx  = '0;
    for (int i = NUM_ENCODERS - 1; i >= 0; i--) begin
      if (enc_marks_q[i]) begin
        enc_pick    = '0;
        enc_pick[i] = 1'b1;
        enc_idx     = IW'(i);
      end
    end
    pot_pick = '0;
    pot_idx  = '0;
    for (int i = NUM_POTS - 1; i >= 0; i--) begin
      if (pot_marks_q[i]) begin
        pot_pick    = '0;
        pot_pick[i] = 1'b1;
        pot_idx     = IW'(i);
      end
    end
  end

  assign is_pop   = (item_i.opcode == ict_pkg::OP_POP);
  assign take_key = is_pop & (|key_marks_q);
  assign take_enc = is_pop & ~(|key_marks_q) & (|enc_marks_q);
  assign take_btn = is_pop & ~(|key_marks_q) & ~(|enc_marks_q) & (|btn_marks_q);
  assign take_pot = is_pop & ~(|key_marks_q) & ~(|enc_marks_q) & ~(|btn_marks_q)
                  & (|pot_marks_q);

  // single read port per array: pop index on a pop, update id otherwise
  assign enc_sel = is_pop ? enc_pick : enc_hit;
  assign pot_sel = is_pop ? pot_pick : pot_hit;

  always_comb begin
    enc_rd = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      if (enc_sel[i]) enc_rd = enc_sum_q[i];
    end
    pot_rd = '0;
    for (int i = 0; i < NUM_POTS; i++) begin
      if (pot_sel[i]) pot_rd = pot_level_q[i];
    end
  end

  assign key_was = |(key_state_q & key_hit);
  assign btn_was = |(btn_state_q & btn_hit);

  // saturating accumulate
  assign enc_acc = $signed({enc_rd[VW-1], enc_rd})
                 + $signed({item_i.step_delta[VW-1], item_i.step_delta});
  always_comb begin
    if (enc_acc > $signed({ict_pkg::SatMax[VW-1], ict_pkg::SatMax})) begin
      enc_new = ict_pkg::SatMax;
    end else if (enc_acc < $signed({ict_pkg::SatMin[VW-1], ict_pkg::SatMin})) begin
      enc_new = ict_pkg::SatMin;
    end else begin
      enc_new = enc_acc[VW-1:0];
    end
  end

  always_comb begin
    key_state_d = key_state_q;
    key_marks_d = key_marks_q;
    btn_state_d = btn_state_q;
    btn_marks_d = btn_marks_q;
    enc_marks_d = enc_marks_q;
    pot_marks_d = pot_marks_q;
    enc_sum_d   = enc_sum_q;
    pot_level_d = pot_level_q;

    case (item_i.opcode)
      ict_pkg::OP_KEY: begin
        if ((|key_hit) && (key_was != item_i.is_pressed)) begin
          key_state_d = item_i.is_pressed ? (key_state_q | key_hit)
                                          : (key_state_q & ~key_hit);
          key_marks_d = key_marks_q | key_hit;
        end
      end
      ict_pkg::OP_BTN: begin
        if ((|btn_hit) && (btn_was != item_i.is_pressed)) begin
          btn_state_d = item_i.is_pressed ? (btn_state_q | btn_hit)
                                          : (btn_state_q & ~btn_hit);
          btn_marks_d = btn_marks_q | btn_hit;
        end
      end
      ict_pkg::OP_ENC: begin
        if ((|enc_hit) && (item_i.step_delta != '0)) begin
          for (int i = 0; i < NUM_ENCODERS; i++) begin
            if (enc_hit[i]) enc_sum_d[i] = enc_new;
          end
          enc_marks_d = enc_marks_q | enc_hit;
        end
      end
      ict_pkg::OP_POT: begin
        if ((|pot_hit) && (pot_rd != item_i.level)) begin
          for (int i = 0; i < NUM_POTS; i++) begin
            if (pot_hit[i]) pot_level_d[i] = item_i.level;
          end
          pot_marks_d = pot_marks_q | pot_hit;
        end
      end
      ict_pkg::OP_POP: begin
        if (take_key) key_marks_d = key_marks_q & ~key_pick;
        if (take_btn) btn_marks_d = btn_marks_q & ~btn_pick;
        if (take_pot) pot_marks_d = pot_marks_q & ~pot_pick;
        if (take_enc) begin
          enc_marks_d = enc_marks_q & ~enc_pick;
          for (int i = 0; i < NUM_ENCODERS; i++) begin
            if (enc_pick[i]) enc_sum_d[i] = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o = '0;
    if (take_key) begin
      result_o.change_kind    = ict_pkg::KIND_KEY;
      result_o.change_index   = key_idx;
      result_o.change_pressed = |(key_state_q & key_pick);
    end else if (take_enc) begin
      result_o.change_kind  = ict_pkg::KIND_ENC;
      result_o.change_index = enc_idx;
      result_o.change_delta = enc_rd;
    end else if (take_btn) begin
      result_o.change_kind    = ict_pkg::KIND_BTN;
      result_o.change_index   = btn_idx;
      result_o.change_pressed = |(btn_state_q & btn_pick);
    end else if (take_pot) begin
      result_o.change_kind  = ict_pkg::KIND_POT;
      result_o.change_index = pot_idx;
      result_o.change_level = pot_rd;
    end
    result_o.pending = (|key_marks_d) | (|enc_marks_d) | (|btn_marks_d) | (|pot_marks_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_state_q <= '0;
      key_marks_q <= '0;
      btn_state_q <= '0;
      btn_marks_q <= '0;
      enc_marks_q <= '0;
      pot_marks_q <= '0;
      for (int i = 0; i < NUM_ENCODERS; i++) enc_sum_q[i] <= '0;
      for (int i = 0; i < NUM_POTS; i++) pot_level_q[i] <= '0;
    end else if (fire_i) begin
      key_state_q <= key_state_d;
      key_marks_q <= key_marks_d;
      btn_state_q <= btn_state_d;
      btn_marks_q <= btn_marks_d;
      enc_marks_q <= enc_marks_d;
      pot_marks_q <= pot_marks_d;
      enc_sum_q   <= enc_sum_d;
      pot_level_q <= pot_level_d;
    end
  end

  a_change_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (result_o.change_kind != ict_pkg::KIND_NONE)
      |-> (item_i.opcode == ict_pkg::OP_POP))
    else $error("change reported for a non-pop item");

  a_pop_drains_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_pop
      && ((|key_marks_q) || (|enc_marks_q) || (|btn_marks_q) || (|pot_marks_q))
      |-> (result_o.change_kind != ict_pkg::KIND_NONE))
    else $error("pop with dirty marks reported no change");

  a_pending_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> (((|key_marks_q) || (|enc_marks_q) || (|btn_marks_q) || (|pot_marks_q))
                == $past(result_o.pending)))
    else $error("pending flag disagrees with stored marks");

endmodule

// ===== rtl/ict_out_stage.sv =====
// result register stage driving the result channel
module ict_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ict_pkg::result_t result_i,
  output logic             room_o,
  ict_out_if.source        out_o
);

  logic             valid_q, valid_d;
  ict_pkg::result_t res_q;

  assign room_o = ~valid_q | out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.change_kind    = res_q.change_kind;
  assign out_o.change_index   = res_q.change_index;
  assign out_o.change_pressed = res_q.change_pressed;
  assign out_o.change_delta   = res_q.change_delta;
  assign out_o.change_level   = res_q.change_level;
  assign out_o.pending        = res_q.pending;

endmodule

// ===== rtl/input_change_tracker.sv =====
// top level of the input change tracker: input stage, tracker core, result stage
//
// usage:
//   in_i carries one item per handshake: a key, encoder, button or pot update
//   (opcode, source_id, is_pressed, step_delta, level) or a pop request
//   out_o returns exactly one result item per input item, in order
//   updates report only the pending flag; a pop reports the lowest dirty entry
//   (keys, then encoders, then buttons, then pots) and clears its mark
// path: an accepted item sits in the input register; once the result register
//   has room, the result register loads as the state updates
// throughput: one item per cycle while out_o is not held; state is read and
//   written in the same cycle the item moves into the result register, so
//   back-to-back items always see the effect of the one before
// stall: while out_o is held, the result register keeps its item and one more
//   item may wait in the input register; after that in_i.ready drops
// reset: rst_ni clears all pressed bits, marks, encoder sums and pot levels,
//   and empties both registers
module input_change_tracker #(
  parameter int unsigned NUM_KEYS     = ict_pkg::NumKeysDef,
  parameter int unsigned NUM_ENCODERS = ict_pkg::NumEncodersDef,
  parameter int unsigned NUM_BUTTONS  = ict_pkg::NumButtonsDef,
  parameter int unsigned NUM_POTS     = ict_pkg::NumPotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ict_in_if.sink    in_i,
  ict_out_if.source out_o
);

  // handshake between the two register stages
  logic             fire;
  logic             room;
  ict_pkg::item_t   item;
  ict_pkg::result_t result;

  ict_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .fire_o (fire),
    .item_o (item)
  );

  // all tracker state lives here and updates only when an item advances
  ict_core #(
    .NUM_KEYS     (NUM_KEYS),
    .NUM_ENCODERS (NUM_ENCODERS),
    .NUM_BUTTONS  (NUM_BUTTONS),
    .NUM_POTS     (NUM_POTS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  ict_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .result_i (result),
    .room_o   (room),
    .out_o    (out_o)
  );

endmodule
